@@ rtl/stb_pkg.sv @@
// Types and constants shared by the software timer bank modules.
package stb_pkg;

  localparam int unsigned NumTimersDefault = 8;
  localparam int unsigned PeriodW          = 32;
  localparam int unsigned IdW              = 4;
  localparam int unsigned MaskW            = 8;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_START   = 2'd1,
    OP_RESTART = 2'd2
  } stb_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_APPLY,
    ST_REPORT
  } stb_state_e;

  typedef struct packed {
    logic [1:0]         op;
    logic [IdW-1:0]     timer_id;
    logic [PeriodW-1:0] period;
  } stb_in_t;

  typedef struct packed {
    logic             running;
    logic             timed_out;
    logic [MaskW-1:0] timeout_mask;
  } stb_out_t;

  typedef struct packed {
    logic load;
    logic step;
    logic apply;
    logic report;
  } stb_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic last;
  } stb_stat_t;

endpackage

@@ rtl/stb_ctrl.sv @@
// Sequencer for the timer bank: accept, sweep or apply, report.
module stb_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  stb_pkg::stb_stat_t stat_i,
  output stb_pkg::stb_cmd_t  cmd_o,
  output logic              busy
);
  import stb_pkg::*;

  stb_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy    = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = stat_i.is_tick ? ST_SWEEP : ST_APPLY;
        end
      end
      ST_SWEEP: begin
        cmd_o.step = 1'b1;
        if (stat_i.last) begin
          state_d = ST_REPORT;
        end
      end
      ST_APPLY: begin
        cmd_o.apply = 1'b1;
        state_d     = ST_REPORT;
      end
      ST_REPORT: begin
        cmd_o.report = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/stb_datapath.sv @@
// Timer state, one-timer-per-cycle tick unit and result register.
module stb_datapath #(
  parameter int unsigned NUM_TIMERS = stb_pkg::NumTimersDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  stb_pkg::stb_in_t   item_i,
  input  stb_pkg::stb_cmd_t  cmd_i,
  output stb_pkg::stb_stat_t stat_o,
  output logic               done_o,
  output stb_pkg::stb_out_t  result_o
);
  import stb_pkg::*;

  localparam int unsigned IdxW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_TIMERS - 1);

  logic [PeriodW-1:0] count_q  [NUM_TIMERS];
  logic [PeriodW-1:0] period_q [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] run_q;
  logic [NUM_TIMERS-1:0] exp_q;

  stb_in_t         item_q;
  logic [IdxW-1:0] idx_q;
  logic            done_q;
  stb_out_t        result_q;

  logic            id_valid;
  logic [IdxW-1:0] id_idx;
  logic [MaskW-1:0] mask;

  assign id_valid = {1'b0, item_q.timer_id} < (IdW + 1)'(NUM_TIMERS);
  assign id_idx   = item_q.timer_id[IdxW-1:0];

  assign stat_o.is_tick = (item_i.op == OP_TICK);
  assign stat_o.last    = (idx_q == LastIdx);

  // item register and sweep index
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.load) begin
      idx_q <= '0;
    end else if (cmd_i.step && !stat_o.last) begin
      idx_q <= idx_q + 1'b1;
    end
  end

  // timer state: one timer per sweep cycle, or the addressed timer on apply
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int t = 0; t < NUM_TIMERS; t++) begin
        count_q[t]  <= '0;
        period_q[t] <= '0;
      end
      run_q <= '0;
      exp_q <= '0;
    end else if (cmd_i.step) begin
      if (run_q[idx_q]) begin
        if (count_q[idx_q] >= period_q[idx_q]) begin
          exp_q[idx_q] <= 1'b1;
        end else begin
          count_q[idx_q] <= count_q[idx_q] + 1'b1;
        end
      end else begin
        exp_q[idx_q]   <= 1'b0;
        count_q[idx_q] <= '0;
      end
    end else if (cmd_i.apply && id_valid) begin
      case (item_q.op)
        OP_START: begin
          count_q[id_idx]  <= '0;
          period_q[id_idx] <= item_q.period;
          run_q[id_idx]    <= 1'b1;
          exp_q[id_idx]    <= 1'b0;
        end
        OP_RESTART: begin
          count_q[id_idx] <= '0;
          run_q[id_idx]   <= 1'b1;
          exp_q[id_idx]   <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // only the first eight timers show in the mask
  for (genvar g = 0; g < MaskW; g++) begin : g_mask
    if (g < NUM_TIMERS) begin : g_on
      assign mask[g] = exp_q[g];
    end else begin : g_off
      assign mask[g] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.report;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.report) begin
      result_q.running      <= id_valid && run_q[id_idx];
      result_q.timed_out    <= id_valid && exp_q[id_idx];
      result_q.timeout_mask <= mask;
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

@@ rtl/software_timer_bank.sv @@
// Top level of the software timer bank: controller plus datapath.
//
//   channel  | handshake          | payload
//   ---------+--------------------+----------------------------
//   item in  | start / busy       | item_i   (stb_in_t)
//   result   | done_o (strobe)    | result_o (stb_out_t)
//
// A tick item goes through sweep and report before done_o, as the tick
// unit visits one timer per cycle; start, restart and unused ops use apply and report.
// busy is high from the cycle after accept until the result register loads;
// a new item can be accepted in the cycle that done_o is high.
// Reset clears all timer counts, periods and flags at once.
// done_o lasts one cycle; the receiver cannot stall it.
module software_timer_bank #(
  parameter int unsigned NUM_TIMERS = stb_pkg::NumTimersDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  stb_pkg::stb_in_t  item_i,
  output logic              busy,
  output logic              done_o,
  output stb_pkg::stb_out_t result_o
);
  import stb_pkg::*;

  stb_cmd_t  cmd;
  stb_stat_t stat;

  stb_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  stb_datapath #(
    .NUM_TIMERS (NUM_TIMERS)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_i),
    .cmd_i    (cmd),
    .stat_o   (stat),
    .done_o   (done_o),
    .result_o (result_o)
  );

endmodule

@@ rtl/stb_checker.sv @@
// Port-level checks for the software timer bank, bound to the top level.
module stb_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              done_o,
  input stb_pkg::stb_out_t result_o
);

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start))
    else $error("busy rose without an item");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy) && !busy)
    else $error("result strobe outside an item");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_expired_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.timed_out |-> result_o.running)
    else $error("expired timer reported as stopped");

endmodule

bind software_timer_bank stb_checker u_stb_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .done_o   (done_o),
  .result_o (result_o)
);
